@@ src/integer_to_roman_numeral_defines.svh @@
// assertion macros used by the top module to check itself
`ifndef INTEGER_TO_ROMAN_NUMERAL_DEFINES_SVH
`define INTEGER_TO_ROMAN_NUMERAL_DEFINES_SVH

// implication in the same cycle
`define IRN_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irn check failed");

// implication in the next cycle
`define IRN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irn check failed");

`endif

@@ src/irn_pkg.sv @@
package irn_pkg;

  localparam int unsigned ValueW   = 12;
  localparam int unsigned CharW    = 7;
  localparam int unsigned MaxValue = 3999;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [CharW-1:0] AsciiNul  = 7'd0;
  localparam logic [CharW-1:0] AsciiStar = 7'd42;
  localparam logic [CharW-1:0] AsciiM    = 7'd77;
  localparam logic [CharW-1:0] AsciiD    = 7'd68;
  localparam logic [CharW-1:0] AsciiC    = 7'd67;
  localparam logic [CharW-1:0] AsciiL    = 7'd76;
  localparam logic [CharW-1:0] AsciiX    = 7'd88;
  localparam logic [CharW-1:0] AsciiV    = 7'd86;
  localparam logic [CharW-1:0] AsciiI    = 7'd73;

  // classified item: decimal digits, thousands first
  typedef struct packed {
    logic       err;
    logic [1:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } q_entry_t;

  // symbol row "**MDCLXVI": position p uses ten [2p], five [2p+1], one [2p+2]
  function automatic logic [CharW-1:0] sym_char(input logic [3:0] idx);
    logic [CharW-1:0] c;
    unique case (idx)
      4'd2:    c = AsciiM;
      4'd3:    c = AsciiD;
      4'd4:    c = AsciiC;
      4'd5:    c = AsciiL;
      4'd6:    c = AsciiX;
      4'd7:    c = AsciiV;
      4'd8:    c = AsciiI;
      default: c = AsciiStar;
    endcase
    return c;
  endfunction

  // number of characters a decimal digit turns into
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] n;
    unique case (d)
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

@@ src/irn_front.sv @@
module irn_front (
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [irn_pkg::ValueW-1:0]     in_value,
  input  logic                           q_ready,
  output logic                           q_push,
  output irn_pkg::q_entry_t              q_wdata
);

  logic [1:0]  thou;
  logic [9:0]  rem_h;
  logic [15:0] prod_h;
  logic [3:0]  hund;
  logic [6:0]  rem_t;
  logic [14:0] prod_t;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic        err;

  always_comb begin
    err = (in_value == '0) || (in_value > 12'(irn_pkg::MaxValue));
    priority if (in_value >= 12'd3000) begin
      thou = 2'd3;
    end else if (in_value >= 12'd2000) begin
      thou = 2'd2;
    end else if (in_value >= 12'd1000) begin
      thou = 2'd1;
    end else begin
      thou = 2'd0;
    end
    rem_h  = 10'(in_value - 12'(thou) * 12'd1000);
    // x/100 for x below 1000 as (x*41)>>12
    prod_h = 16'(rem_h) * 16'd41;
    hund   = prod_h[15:12];
    rem_t  = 7'(rem_h - 10'(hund) * 10'd100);
    // x/10 for x below 100 as (x*205)>>11
    prod_t = 15'(rem_t) * 15'd205;
    tens   = prod_t[14:11];
    ones   = 4'(rem_t - 7'(tens) * 7'd10);
  end

  assign q_wdata.err = err;
  assign q_wdata.d3  = thou;
  assign q_wdata.d2  = hund;
  assign q_wdata.d1  = tens;
  assign q_wdata.d0  = ones;
  assign q_push      = in_valid && q_ready;
  assign in_stall    = !q_ready;

endmodule

@@ src/irn_queue.sv @@
module irn_queue #(
  parameter int unsigned Depth = irn_pkg::QueueDepthDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  irn_pkg::q_entry_t wdata,
  output logic              ready,
  input  logic              pop,
  output logic              rvalid,
  output irn_pkg::q_entry_t rdata
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  irn_pkg::q_entry_t mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r;
  logic [PtrW-1:0]   rd_ptr_r;
  logic [CntW-1:0]   count_r;

  assign ready  = (count_r != CntW'(Depth));
  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ src/irn_back.sv @@
module irn_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  irn_pkg::q_entry_t              q_rdata,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [irn_pkg::CharW-1:0]      out_ascii_char,
  output logic                           out_last,
  output logic                           out_out_of_range
);

  typedef enum logic [1:0] {
    ROLE_TEN  = 2'd0,
    ROLE_FIVE = 2'd1,
    ROLE_ONE  = 2'd2
  } role_t;

  logic                      busy_r;
  logic                      err_r;
  logic [3:0]                dig_r [4];
  logic [1:0]                pos_r;
  logic [1:0]                k_r;
  logic                      out_valid_r;
  logic [irn_pkg::CharW-1:0] char_r;
  logic                      last_r;
  logic                      oor_r;

  logic [3:0]                cur_dig;
  logic [2:0]                cur_len;
  role_t                     role;
  logic [irn_pkg::CharW-1:0] cur_char;
  logic                      digit_end;
  logic                      rest_zero;
  logic [1:0]                next_pos;
  logic                      item_end;
  logic                      out_can;
  logic                      emit;
  logic                      load;
  logic [1:0]                first_pos;

  assign cur_dig = dig_r[pos_r];
  assign cur_len = irn_pkg::digit_len(cur_dig);

  always_comb begin
    priority if (cur_dig == 4'd9) begin
      role = (k_r == 2'd0) ? ROLE_ONE : ROLE_TEN;
    end else if (cur_dig == 4'd4) begin
      role = (k_r == 2'd0) ? ROLE_ONE : ROLE_FIVE;
    end else if (cur_dig >= 4'd5 && k_r == 2'd0) begin
      role = ROLE_FIVE;
    end else begin
      role = ROLE_ONE;
    end
  end

  assign cur_char = err_r ? irn_pkg::AsciiNul
                          : irn_pkg::sym_char({1'b0, pos_r, 1'b0} + {2'b00, role});
  assign digit_end = ({1'b0, k_r} == cur_len - 3'd1);

  // nearest lower-order position with a nonzero digit
  always_comb begin
    rest_zero = 1'b1;
    next_pos  = pos_r;
    for (int p = 3; p >= 1; p--) begin
      if (2'(p) > pos_r && dig_r[p] != 4'd0) begin
        rest_zero = 1'b0;
        next_pos  = 2'(p);
      end
    end
  end

  always_comb begin
    priority if (q_rdata.d3 != 2'd0) begin
      first_pos = 2'd0;
    end else if (q_rdata.d2 != 4'd0) begin
      first_pos = 2'd1;
    end else if (q_rdata.d1 != 4'd0) begin
      first_pos = 2'd2;
    end else begin
      first_pos = 2'd3;
    end
  end

  assign item_end = err_r || (digit_end && rest_zero);
  assign out_can  = !out_valid_r || !out_stall;
  assign emit     = busy_r && out_can;
  // next item is picked up in the cycle its predecessor sends its final character
  assign load     = q_valid && (!busy_r || (emit && item_end));
  assign q_pop    = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && item_end) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r <= cur_char;
      last_r <= item_end;
      oor_r  <= err_r;
    end
    if (load) begin
      err_r    <= q_rdata.err;
      dig_r[0] <= {2'b00, q_rdata.d3};
      dig_r[1] <= q_rdata.d2;
      dig_r[2] <= q_rdata.d1;
      dig_r[3] <= q_rdata.d0;
      pos_r    <= first_pos;
      k_r      <= 2'd0;
    end else if (emit && !item_end) begin
      if (digit_end) begin
        pos_r <= next_pos;
        k_r   <= 2'd0;
      end else begin
        k_r <= k_r + 2'd1;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ascii_char   = char_r;
  assign out_last         = last_r;
  assign out_out_of_range = oor_r;

endmodule

@@ src/integer_to_roman_numeral.sv @@
// channel   direction  ports
// in_       input      in_valid, in_stall, in_value[11:0]
// out_      output     out_valid, out_stall, out_ascii_char[6:0], out_last, out_out_of_range
//
// each value yields 1 to 15 characters, one transfer per cycle on the output side
// while out_stall is low; an item holds the character sequencer until its last one is sent
// the digit split and range check are combinational; from input transfer to the first
// character an item passes the queue entry, the digit registers and the output register
// rst_n is synchronous and active low; it empties the queue and drops out_valid
// either side may stall independently; the queue holds classified items meanwhile
`include "integer_to_roman_numeral_defines.svh"

module integer_to_roman_numeral #(
  parameter int unsigned QueueDepth = irn_pkg::QueueDepthDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [irn_pkg::ValueW-1:0]     in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [irn_pkg::CharW-1:0]      out_ascii_char,
  output logic                           out_last,
  output logic                           out_out_of_range
);

  logic              q_push;
  logic              q_ready;
  logic              q_pop;
  logic              q_valid;
  irn_pkg::q_entry_t q_wdata;
  irn_pkg::q_entry_t q_rdata;

  irn_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  irn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .ready  (q_ready),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  irn_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ascii_char   (out_ascii_char),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

  // error result is a lone nul character
  `IRN_ASSERT_SAME(a_err_single, out_valid && out_out_of_range,
                   out_last && (out_ascii_char == irn_pkg::AsciiNul))
  `IRN_ASSERT_SAME(a_char_nonzero, out_valid && !out_out_of_range,
                   out_ascii_char != irn_pkg::AsciiNul)
  // a numeral is sent without gaps once it has started
  `IRN_ASSERT_NEXT(a_no_gap, out_valid && !out_stall && !out_last, out_valid)

endmodule
